// File: design/ccirc_pkg.sv
`default_nettype none

package ccirc_pkg;

  // Coordinate and result widths.
  localparam int COORD_W = 32;
  localparam int CONST_W = 64;

  // Internal datapath widths, all derived from the coordinate width.
  localparam int DIF_W  = COORD_W + 1;          // point differences
  localparam int PRD_W  = 2 * DIF_W;            // products of two differences
  localparam int SQS_W  = 2 * COORD_W + 1;      // sums of two squares
  localparam int DET_W  = 2 * COORD_W + 4;      // doubled determinant
  localparam int DMAG_W = 2 * COORD_W + 2;      // determinant magnitude
  localparam int SLO_W  = COORD_W + 1;          // low split of a square sum
  localparam int NUM_W  = 3 * COORD_W + 4;      // bisector numerators
  localparam int NMAG_W = 3 * COORD_W + 2;      // numerator and quotient magnitude
  localparam int REM_W  = DMAG_W + 1;           // divider partial remainder
  localparam int UX_W   = NMAG_W + 1;           // signed center offset
  localparam int HK_W   = UX_W + 1;             // unsaturated center
  localparam int LIMB_W = COORD_W;              // limb of the offset for products
  localparam int NLIMB  = (UX_W + LIMB_W - 1) / LIMB_W;
  localparam int LPR_W  = 2 * COORD_W + 1;      // coordinate times limb
  localparam int PP_W   = LPR_W + 1;            // pair of limb products
  localparam int C_W    = NLIMB * LIMB_W + 8;   // unsaturated constant term
  localparam int RAD_W  = 2 * COORD_W;          // square root radicand
  localparam int SREM_W = COORD_W + 4;          // square root remainder

  // Pipeline depth of the long units.
  localparam int DIV_STAGES  = NMAG_W;
  localparam int SQRT_STAGES = COORD_W;
  localparam int NSTG = 6 + (DIV_STAGES + 1) + 2 + 5 + (SQRT_STAGES + 1) + 1;

  // Largest squared distance whose rounded root still fits the radius.
  localparam logic [SQS_W-1:0] RAD_LIM = {1'b0, {COORD_W{1'b1}}, {COORD_W{1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } ccirc_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic        [COORD_W-1:0] radius;
    logic signed [CONST_W-1:0] const_term;
    logic                      collinear;
  } ccirc_out_t;

endpackage

`default_nettype wire

// File: design/circumcircle_from_three_points.sv
`default_nettype none

// Circumcircle of three points, fully pipelined.
// Input channel pts (pts_valid / pts_ready) carries one point triple per
// transaction in signed Q16.16. Output channel circ (circ_valid / circ_ready)
// returns the center, the rounded radius, the constant term h^2+k^2-r^2 in
// Q32.32 and a collinear flag; out-of-range results saturate, and collinear
// input returns zeros with the flag set.
// Throughput is one transaction per cycle while the skid register is empty.
// The depth is set by the radix-2 divider for the center (98 stages, one
// quotient bit each) and the digit-by-digit square root for the radius
// (32 stages, one root bit each); the remaining stages hold the products
// and wide sums, cut to one multiplier or one wide add per stage.
// All stages advance together. When the receiver stalls, the output
// register holds its transaction and a skid register catches the one
// leaving the pipeline; pts_ready drops only while the skid is full, so
// nothing is lost or repeated.
// Synchronous reset clears the valid bits of every stage and of both
// output registers; the data registers are not reset.
module circumcircle_from_three_points (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pts_valid,
  output logic                   pts_ready,
  input  ccirc_pkg::ccirc_in_t   pts,
  output logic                   circ_valid,
  input  logic                   circ_ready,
  output ccirc_pkg::ccirc_out_t  circ
);
  import ccirc_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax, ay;
    logic signed [DIF_W-1:0]   bdx, bdy, cdx, cdy;
  } f1_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax, ay;
    logic signed [DIF_W-1:0]   bdx, bdy, cdx, cdy;
    logic signed [PRD_W-1:0]   bb_x, bb_y, cc_x, cc_y, cr_1, cr_2;
  } f2_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax, ay;
    logic signed [DIF_W-1:0]   bdx, bdy, cdx, cdy;
    logic        [SQS_W-1:0]   sb, sc;
    logic signed [DET_W-1:0]   det;
  } f3_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax, ay;
    logic signed [DET_W-1:0]   det;
    logic signed [PRD_W:0]     xl1, xl2, yl1, yl2;
    logic signed [PRD_W-1:0]   xh1, xh2, yh1, yh2;
  } f4_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax, ay;
    logic signed [DET_W-1:0]   det;
    logic signed [NUM_W-1:0]   x1, x2, y1, y2;
  } f5_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax, ay;
    logic signed [DET_W-1:0]   det;
    logic signed [NUM_W-1:0]   nx, ny;
  } f6_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax, ay;
    logic        [DMAG_W-1:0]  dm;
    logic        [NMAG_W-1:0]  nxs, nys, qx, qy;
    logic        [REM_W-1:0]   rx, ry;
    logic                      neg_x, neg_y, coll;
  } dv_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax, ay;
    logic        [NMAG_W-1:0]  mx, my;
    logic                      neg_x, neg_y, coll;
  } r1_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax, ay;
    logic signed [UX_W-1:0]    ux, uy;
    logic        [NMAG_W-1:0]  mx, my;
    logic                      coll;
  } r2_t;

  typedef struct packed {
    logic signed [HK_W-1:0]              h, k;
    logic signed [2*COORD_W-1:0]         axx, ayy;
    logic        [NLIMB-1:0][LPR_W-1:0]  pxl, pyl;
    logic                                small_x, small_y;
    logic        [2*COORD_W-1:0]         uxx, uyy;
    logic                                coll;
  } p1_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]          hs, ks;
    logic        [SQS_W-1:0]            sq;
    logic        [NLIMB-1:0][PP_W-1:0]  pp;
    logic        [SQS_W-1:0]            ss;
    logic                               fits, coll;
  } p2_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] hs, ks;
    logic        [SQS_W-1:0]   sq;
    logic signed [C_W-1:0]     lo, hi;
    logic                      rsat;
    logic        [RAD_W-1:0]   s64;
    logic                      coll;
  } p3_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] hs, ks;
    logic        [SQS_W-1:0]   sq;
    logic signed [C_W-1:0]     t;
    logic                      rsat;
    logic        [RAD_W-1:0]   s64;
    logic                      coll;
  } p4_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] hs, ks;
    logic signed [C_W-1:0]     c;
    logic                      rsat;
    logic        [RAD_W-1:0]   s64;
    logic                      coll;
  } p5_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] hs, ks;
    logic signed [CONST_W-1:0] c64;
    logic                      rsat;
    logic        [RAD_W-1:0]   rad;
    logic        [SREM_W-1:0]  rem;
    logic        [COORD_W-1:0] root;
    logic                      coll;
  } sq_t;

  // One restoring quotient bit for both divisions.
  function automatic dv_t div_step(input dv_t s);
    dv_t o;
    logic [REM_W-1:0] tx, ty;
    o  = s;
    tx = {s.rx[REM_W-2:0], s.nxs[NMAG_W-1]};
    ty = {s.ry[REM_W-2:0], s.nys[NMAG_W-1]};
    o.nxs = {s.nxs[NMAG_W-2:0], 1'b0};
    o.nys = {s.nys[NMAG_W-2:0], 1'b0};
    if (tx >= {1'b0, s.dm}) begin
      o.rx = tx - {1'b0, s.dm};
      o.qx = {s.qx[NMAG_W-2:0], 1'b1};
    end else begin
      o.rx = tx;
      o.qx = {s.qx[NMAG_W-2:0], 1'b0};
    end
    if (ty >= {1'b0, s.dm}) begin
      o.ry = ty - {1'b0, s.dm};
      o.qy = {s.qy[NMAG_W-2:0], 1'b1};
    end else begin
      o.ry = ty;
      o.qy = {s.qy[NMAG_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // One root bit of the digit-by-digit square root.
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t o;
    logic [SREM_W-1:0] tr, tt;
    o  = s;
    tr = {s.rem[SREM_W-3:0], s.rad[RAD_W-1 -: 2]};
    tt = SREM_W'({s.root, 2'b01});
    o.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (tr >= tt) begin
      o.rem  = tr - tt;
      o.root = {s.root[COORD_W-2:0], 1'b1};
    end else begin
      o.rem  = tr;
      o.root = {s.root[COORD_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // Clamp the center to the coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_hk(input logic signed [HK_W-1:0] v);
    logic [HK_W-COORD_W:0] top;
    top = v[HK_W-1:COORD_W-1];
    if (top == '0 || top == '1) begin
      return v[COORD_W-1:0];
    end else if (v[HK_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  // Clamp the constant term to its range.
  function automatic logic signed [CONST_W-1:0] sat_c(input logic signed [C_W-1:0] v);
    logic [C_W-CONST_W:0] top;
    top = v[C_W-1:CONST_W-1];
    if (top == '0 || top == '1) begin
      return v[CONST_W-1:0];
    end else if (v[C_W-1]) begin
      return {1'b1, {(CONST_W-1){1'b0}}};
    end else begin
      return {1'b0, {(CONST_W-1){1'b1}}};
    end
  endfunction

  logic en;
  logic [NSTG-1:0] vld;

  f1_t f1, f1_next;
  f2_t f2, f2_next;
  f3_t f3, f3_next;
  f4_t f4, f4_next;
  f5_t f5, f5_next;
  f6_t f6, f6_next;
  dv_t dv      [0:DIV_STAGES];
  dv_t dv_next [0:DIV_STAGES];
  r1_t r1, r1_next;
  r2_t r2, r2_next;
  p1_t p1, p1_next;
  p2_t p2, p2_next;
  p3_t p3, p3_next;
  p4_t p4, p4_next;
  p5_t p5, p5_next;
  sq_t sq      [0:SQRT_STAGES];
  sq_t sq_next [0:SQRT_STAGES];
  ccirc_out_t sf, sf_next;

  logic       out_vld, skid_vld;
  ccirc_out_t out_reg, skid;

  // The pipeline moves whenever the skid register is free.
  assign en        = ~skid_vld;
  assign pts_ready = en;

  // Differences to the first point, then their products.
  always_comb begin
    f1_next.ax  = pts.ax;
    f1_next.ay  = pts.ay;
    f1_next.bdx = DIF_W'(pts.bx) - DIF_W'(pts.ax);
    f1_next.bdy = DIF_W'(pts.by_coord) - DIF_W'(pts.ay);
    f1_next.cdx = DIF_W'(pts.cx) - DIF_W'(pts.ax);
    f1_next.cdy = DIF_W'(pts.cy) - DIF_W'(pts.ay);

    f2_next.ax   = f1.ax;
    f2_next.ay   = f1.ay;
    f2_next.bdx  = f1.bdx;
    f2_next.bdy  = f1.bdy;
    f2_next.cdx  = f1.cdx;
    f2_next.cdy  = f1.cdy;
    f2_next.bb_x = f1.bdx * f1.bdx;
    f2_next.bb_y = f1.bdy * f1.bdy;
    f2_next.cc_x = f1.cdx * f1.cdx;
    f2_next.cc_y = f1.cdy * f1.cdy;
    f2_next.cr_1 = f1.bdx * f1.cdy;
    f2_next.cr_2 = f1.bdy * f1.cdx;
  end

  // Squared edge lengths and the doubled determinant.
  always_comb begin
    f3_next.ax  = f2.ax;
    f3_next.ay  = f2.ay;
    f3_next.bdx = f2.bdx;
    f3_next.bdy = f2.bdy;
    f3_next.cdx = f2.cdx;
    f3_next.cdy = f2.cdy;
    f3_next.sb  = {1'b0, f2.bb_x[2*COORD_W-1:0]} + {1'b0, f2.bb_y[2*COORD_W-1:0]};
    f3_next.sc  = {1'b0, f2.cc_x[2*COORD_W-1:0]} + {1'b0, f2.cc_y[2*COORD_W-1:0]};
    f3_next.det = (DET_W'(f2.cr_1) - DET_W'(f2.cr_2)) <<< 1;
  end

  // Numerator partial products, with each square sum split in two halves.
  always_comb begin
    f4_next.ax  = f3.ax;
    f4_next.ay  = f3.ay;
    f4_next.det = f3.det;
    f4_next.xl1 = f3.cdy * $signed({1'b0, f3.sb[SLO_W-1:0]});
    f4_next.xh1 = f3.cdy * $signed({1'b0, f3.sb[SQS_W-1:SLO_W]});
    f4_next.xl2 = f3.bdy * $signed({1'b0, f3.sc[SLO_W-1:0]});
    f4_next.xh2 = f3.bdy * $signed({1'b0, f3.sc[SQS_W-1:SLO_W]});
    f4_next.yl1 = f3.bdx * $signed({1'b0, f3.sc[SLO_W-1:0]});
    f4_next.yh1 = f3.bdx * $signed({1'b0, f3.sc[SQS_W-1:SLO_W]});
    f4_next.yl2 = f3.cdx * $signed({1'b0, f3.sb[SLO_W-1:0]});
    f4_next.yh2 = f3.cdx * $signed({1'b0, f3.sb[SQS_W-1:SLO_W]});
  end

  // Recombine the halves, then form both numerators.
  always_comb begin
    f5_next.ax  = f4.ax;
    f5_next.ay  = f4.ay;
    f5_next.det = f4.det;
    f5_next.x1  = (NUM_W'(f4.xh1) <<< SLO_W) + NUM_W'(f4.xl1);
    f5_next.x2  = (NUM_W'(f4.xh2) <<< SLO_W) + NUM_W'(f4.xl2);
    f5_next.y1  = (NUM_W'(f4.yh1) <<< SLO_W) + NUM_W'(f4.yl1);
    f5_next.y2  = (NUM_W'(f4.yh2) <<< SLO_W) + NUM_W'(f4.yl2);

    f6_next.ax  = f5.ax;
    f6_next.ay  = f5.ay;
    f6_next.det = f5.det;
    f6_next.nx  = f5.x1 - f5.x2;
    f6_next.ny  = f5.y1 - f5.y2;
  end

  // Divider entry: magnitudes and quotient signs, then one bit per stage.
  always_comb begin
    logic signed [DET_W-1:0] dabs;
    logic signed [NUM_W-1:0] xabs, yabs;
    dabs = f6.det[DET_W-1] ? -f6.det : f6.det;
    xabs = f6.nx[NUM_W-1] ? -f6.nx : f6.nx;
    yabs = f6.ny[NUM_W-1] ? -f6.ny : f6.ny;
    dv_next[0].ax    = f6.ax;
    dv_next[0].ay    = f6.ay;
    dv_next[0].dm    = dabs[DMAG_W-1:0];
    dv_next[0].nxs   = xabs[NMAG_W-1:0];
    dv_next[0].nys   = yabs[NMAG_W-1:0];
    dv_next[0].qx    = '0;
    dv_next[0].qy    = '0;
    dv_next[0].rx    = '0;
    dv_next[0].ry    = '0;
    dv_next[0].neg_x = f6.nx[NUM_W-1] ^ f6.det[DET_W-1];
    dv_next[0].neg_y = f6.ny[NUM_W-1] ^ f6.det[DET_W-1];
    dv_next[0].coll  = (f6.det == '0);
    for (int i = 1; i <= DIV_STAGES; i++) begin
      dv_next[i] = div_step(dv[i-1]);
    end
  end

  // Round the quotients half away from zero, then restore their signs.
  always_comb begin
    r1_next.ax    = dv[DIV_STAGES].ax;
    r1_next.ay    = dv[DIV_STAGES].ay;
    r1_next.mx    = dv[DIV_STAGES].qx + NMAG_W'({dv[DIV_STAGES].rx[REM_W-2:0], 1'b0}
                    >= {1'b0, dv[DIV_STAGES].dm});
    r1_next.my    = dv[DIV_STAGES].qy + NMAG_W'({dv[DIV_STAGES].ry[REM_W-2:0], 1'b0}
                    >= {1'b0, dv[DIV_STAGES].dm});
    r1_next.neg_x = dv[DIV_STAGES].neg_x;
    r1_next.neg_y = dv[DIV_STAGES].neg_y;
    r1_next.coll  = dv[DIV_STAGES].coll;

    r2_next.ax   = r1.ax;
    r2_next.ay   = r1.ay;
    r2_next.ux   = r1.neg_x ? -$signed({1'b0, r1.mx}) : $signed({1'b0, r1.mx});
    r2_next.uy   = r1.neg_y ? -$signed({1'b0, r1.my}) : $signed({1'b0, r1.my});
    r2_next.mx   = r1.mx;
    r2_next.my   = r1.my;
    r2_next.coll = r1.coll;
  end

  // Center, limb products for the constant term, and small squared offsets.
  always_comb begin
    logic signed [NLIMB*LIMB_W-1:0] uxe, uye;
    logic signed [LPR_W-1:0]        px, py;
    uxe = (NLIMB*LIMB_W)'(r2.ux);
    uye = (NLIMB*LIMB_W)'(r2.uy);
    p1_next.h   = HK_W'(r2.ax) + HK_W'(r2.ux);
    p1_next.k   = HK_W'(r2.ay) + HK_W'(r2.uy);
    p1_next.axx = r2.ax * r2.ax;
    p1_next.ayy = r2.ay * r2.ay;
    for (int j = 0; j < NLIMB; j++) begin
      if (j == NLIMB - 1) begin
        px = r2.ax * $signed(uxe[j*LIMB_W +: LIMB_W]);
        py = r2.ay * $signed(uye[j*LIMB_W +: LIMB_W]);
      end else begin
        px = r2.ax * $signed({1'b0, uxe[j*LIMB_W +: LIMB_W]});
        py = r2.ay * $signed({1'b0, uye[j*LIMB_W +: LIMB_W]});
      end
      p1_next.pxl[j] = px;
      p1_next.pyl[j] = py;
    end
    p1_next.small_x = (r2.mx[NMAG_W-1:COORD_W] == '0);
    p1_next.small_y = (r2.my[NMAG_W-1:COORD_W] == '0);
    p1_next.uxx     = r2.mx[COORD_W-1:0] * r2.mx[COORD_W-1:0];
    p1_next.uyy     = r2.my[COORD_W-1:0] * r2.my[COORD_W-1:0];
    p1_next.coll    = r2.coll;
  end

  // Saturate the center and add the products in pairs.
  always_comb begin
    logic signed [PP_W-1:0] psum;
    p2_next.hs = sat_hk(p1.h);
    p2_next.ks = sat_hk(p1.k);
    p2_next.sq = {1'b0, p1.axx} + {1'b0, p1.ayy};
    for (int j = 0; j < NLIMB; j++) begin
      psum = $signed(p1.pxl[j]) + $signed(p1.pyl[j]);
      p2_next.pp[j] = psum;
    end
    p2_next.ss    = {1'b0, p1.uxx} + {1'b0, p1.uyy};
    p2_next.fits  = p1.small_x & p1.small_y;
    p2_next.coll  = p1.coll;
  end

  // Fold the limb sums into the cross term.
  always_comb begin
    p3_next.hs   = p2.hs;
    p3_next.ks   = p2.ks;
    p3_next.sq   = p2.sq;
    p3_next.lo   = C_W'($signed(p2.pp[0])) + (C_W'($signed(p2.pp[1])) <<< LIMB_W);
    p3_next.hi   = C_W'($signed(p2.pp[2])) + (C_W'($signed(p2.pp[3])) <<< LIMB_W);
    p3_next.rsat = ~p2.fits | (p2.ss > RAD_LIM);
    p3_next.s64  = p2.ss[RAD_W-1:0];
    p3_next.coll = p2.coll;

    p4_next.hs   = p3.hs;
    p4_next.ks   = p3.ks;
    p4_next.sq   = p3.sq;
    p4_next.t    = p3.lo + (p3.hi <<< (2*LIMB_W));
    p4_next.rsat = p3.rsat;
    p4_next.s64  = p3.s64;
    p4_next.coll = p3.coll;

    p5_next.hs   = p4.hs;
    p5_next.ks   = p4.ks;
    p5_next.c    = $signed(C_W'(p4.sq)) + (p4.t <<< 1);
    p5_next.rsat = p4.rsat;
    p5_next.s64  = p4.s64;
    p5_next.coll = p4.coll;
  end

  // Square root entry, then one root bit per stage.
  always_comb begin
    sq_next[0].hs   = p5.hs;
    sq_next[0].ks   = p5.ks;
    sq_next[0].c64  = sat_c(p5.c);
    sq_next[0].rsat = p5.rsat;
    sq_next[0].rad  = p5.s64;
    sq_next[0].rem  = '0;
    sq_next[0].root = '0;
    sq_next[0].coll = p5.coll;
    for (int i = 1; i <= SQRT_STAGES; i++) begin
      sq_next[i] = sqrt_step(sq[i-1]);
    end
  end

  // Round the root and zero everything for collinear points.
  always_comb begin
    logic [COORD_W-1:0] rnd;
    rnd = sq[SQRT_STAGES].root
          + COORD_W'(sq[SQRT_STAGES].rem > SREM_W'(sq[SQRT_STAGES].root));
    if (sq[SQRT_STAGES].coll) begin
      sf_next.center_x   = '0;
      sf_next.center_y   = '0;
      sf_next.radius     = '0;
      sf_next.const_term = '0;
      sf_next.collinear  = 1'b1;
    end else begin
      sf_next.center_x   = sq[SQRT_STAGES].hs;
      sf_next.center_y   = sq[SQRT_STAGES].ks;
      sf_next.radius     = sq[SQRT_STAGES].rsat ? '1 : rnd;
      sf_next.const_term = sq[SQRT_STAGES].c64;
      sf_next.collinear  = 1'b0;
    end
  end

  // Pipeline data registers.
  always_ff @(posedge clk) begin
    if (en) begin
      f1 <= f1_next;
      f2 <= f2_next;
      f3 <= f3_next;
      f4 <= f4_next;
      f5 <= f5_next;
      f6 <= f6_next;
      dv <= dv_next;
      r1 <= r1_next;
      r2 <= r2_next;
      p1 <= p1_next;
      p2 <= p2_next;
      p3 <= p3_next;
      p4 <= p4_next;
      p5 <= p5_next;
      sq <= sq_next;
      sf <= sf_next;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], pts_valid};
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (circ_ready) begin
        out_reg  <= skid;
        skid_vld <= 1'b0;
      end
    end else if (out_vld && !circ_ready) begin
      if (vld[NSTG-1]) begin
        skid     <= sf;
        skid_vld <= 1'b1;
      end
    end else begin
      out_vld <= vld[NSTG-1];
      out_reg <= sf;
    end
  end

  assign circ_valid = out_vld;
  assign circ       = out_reg;

endmodule

`default_nettype wire
